FILE: rtl/pwl_pkg.sv
`default_nettype none

package pwl_pkg;

  // table and field geometry
  localparam int MAX_POINTS   = 64;
  localparam int FRAC_BITS    = 16;
  localparam int DATA_W       = 32;
  localparam int CFG_W        = 7;
  localparam int ENTRY_IDX_W  = 6;
  localparam int IDX_W        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  // divider: numerator magnitude is |q - x0| shifted up by the fraction bits
  localparam int NUM_W        = DATA_W + FRAC_BITS;
  localparam int DIV_STEPS    = NUM_W;
  // multiplier: fraction times a 33-bit ordinate difference
  localparam int MUL_STEPS    = DATA_W + 1;
  localparam int STEP_W       = $clog2((DIV_STEPS > MUL_STEPS) ? DIV_STEPS : MUL_STEPS);
  localparam int HI_W         = DATA_W + 2;
  localparam int LO_W         = DATA_W + 1;
  localparam int SH_W         = HI_W + LO_W - FRAC_BITS;
  localparam int SUM_W        = SH_W + 1;

  localparam logic [CFG_W-1:0]  POINTS_RESET = CFG_W'(2);
  localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // item mode codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_DIV,
    S_FRAC,
    S_MUL,
    S_SUM,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/pwl_in_if.sv
`default_nettype none

interface pwl_in_if import pwl_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [ENTRY_IDX_W-1:0]   entry_index;
  logic signed [DATA_W-1:0] entry_x;
  logic signed [DATA_W-1:0] entry_y;
  logic signed [DATA_W-1:0] query_x;

  modport source (
    output valid, mode, entry_index, entry_x, entry_y, query_x,
    input  ready
  );

  modport sink (
    input  valid, mode, entry_index, entry_x, entry_y, query_x,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/pwl_out_if.sv
`default_nettype none

interface pwl_out_if import pwl_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     in_segment;
  logic                     saturated;

  modport source (
    output valid, value, in_segment, saturated,
    input  ready
  );

  modport sink (
    input  valid, value, in_segment, saturated,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/piecewise_linear_lookup_core.sv
// load beats are taken back to back; a query scans the table for its segment, then divides,
// multiplies and adds y0; a zero-width segment or a query past the last point skips those
// throughput: set by the breakpoint scan (one table read a cycle), the 48-step divider
// and the 33-step shift-add multiplier; next beat taken the cycle after a result is parked
// reset: synchronous active-low rst_n clears the sequencer and output valid, sets
// the point count points_r to 2; the breakpoint table is not cleared
`default_nettype none

module piecewise_linear_lookup_core import pwl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  pwl_in_if.sink                in_bus,
  pwl_out_if.source             out_bus,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  // control
  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  points_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  rd_addr;
  logic [STEP_W-1:0] step_r;
  logic              in_acc;
  logic              is_load;
  logic              out_load;

  // breakpoint table, one read port with registered data
  entry_t            bp_mem_r [MAX_POINTS];
  entry_t            rdata_r;

  // segment end points and query
  logic signed [DATA_W-1:0] q_r, x0_r, y0_r, x1_r, y1_r;

  // divider
  logic [NUM_W-1:0]  nq_r;      // numerator bits shift out, quotient bits shift in
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] dmag_r;
  logic              neg_r;

  // multiplier
  logic signed [DATA_W-1:0] frac_r;
  logic signed [HI_W-1:0]   hi_r;
  logic [LO_W-1:0]          lo_r;

  // result and output stage
  logic signed [DATA_W-1:0] res_r;
  logic                     seg_r, sat_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_seg_r, out_sat_r;

  // datapath combinational terms
  logic signed [DATA_W:0]   dq, den, dy;
  logic [DATA_W-1:0]        dq_mag, den_mag;
  logic [DATA_W:0]          div_part, div_diff;
  logic                     div_ge;
  logic                     pos_ovf, neg_ovf;
  logic signed [HI_W-1:0]   frac_ext, mul_add, mul_sum;
  logic signed [SH_W-1:0]   prod_sh;
  logic signed [SUM_W-1:0]  sum;
  logic                     sum_ovf;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign is_load      = (in_bus.mode == MODE_LOAD);

  // clamp the configured count into 2 .. MAX_POINTS, keep the index of the last point
  always_comb begin
    if (points_r < CFG_W'(2)) begin
      last_idx = IDX_W'(1);
    end else if (32'(points_r) > 32'(MAX_POINTS)) begin
      last_idx = IDX_W'(MAX_POINTS - 1);
    end else begin
      last_idx = IDX_W'(32'(points_r) - 32'd1);
    end
  end

  // the read one ahead of the scan index; idle prefetches slot 0
  assign rd_addr = (state_r == S_SCAN) ? idx_r + IDX_W'(1) : '0;

  // segment set-up: widths and magnitudes of the first division operands
  assign dq      = {q_r[DATA_W-1], q_r} - {x0_r[DATA_W-1], x0_r};
  assign den     = {x1_r[DATA_W-1], x1_r} - {x0_r[DATA_W-1], x0_r};
  assign dy      = {y1_r[DATA_W-1], y1_r} - {y0_r[DATA_W-1], y0_r};
  assign dq_mag  = dq[DATA_W] ? DATA_W'(-dq) : dq[DATA_W-1:0];
  assign den_mag = den[DATA_W] ? DATA_W'(-den) : den[DATA_W-1:0];

  // restoring divider, one quotient bit a cycle
  assign div_part = {rem_r, nq_r[NUM_W-1]};
  assign div_ge   = (div_part >= {1'b0, dmag_r});
  assign div_diff = div_part - {1'b0, dmag_r};

  // fraction saturation on the quotient magnitude
  assign pos_ovf = |nq_r[NUM_W-1:DATA_W-1];
  assign neg_ovf = (|nq_r[NUM_W-1:DATA_W]) || (nq_r[DATA_W-1] && (|nq_r[DATA_W-2:0]));

  // shift-add multiplier over the bits of the ordinate difference, sign bit subtracts
  assign frac_ext = {{(HI_W-DATA_W){frac_r[DATA_W-1]}}, frac_r};
  always_comb begin
    if (!lo_r[0]) begin
      mul_add = '0;
    end else if (step_r == STEP_W'(MUL_STEPS - 1)) begin
      mul_add = -frac_ext;
    end else begin
      mul_add = frac_ext;
    end
  end
  assign mul_sum = hi_r + mul_add;

  // floor shift of the product and add of y0
  assign prod_sh = {hi_r, lo_r[LO_W-1:FRAC_BITS]};
  assign sum     = {prod_sh[SH_W-1], prod_sh}
                 + {{(SUM_W-DATA_W){y0_r[DATA_W-1]}}, y0_r};
  assign sum_ovf = !((&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1]));

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !is_load) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (idx_r != '0) begin
          if (rdata_r.x > q_r) begin
            state_nxt = S_PREP;
          end else if (idx_r == last_idx) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_PREP: begin
        state_nxt = (den == '0) ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = S_FRAC;
      end
      S_FRAC: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (step_r == STEP_W'(MUL_STEPS - 1)) state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= POINTS_RESET;
    end else if (cfg_we) begin
      points_r <= cfg_wdata;
    end
  end

  // breakpoint table; slots past the table are dropped
  always_ff @(posedge clk) begin
    if (in_acc && is_load && (32'(in_bus.entry_index) < 32'(MAX_POINTS))) begin
      bp_mem_r[IDX_W'(in_bus.entry_index)] <= '{x: in_bus.entry_x, y: in_bus.entry_y};
    end
    rdata_r <= bp_mem_r[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        q_r   <= in_bus.query_x;
        idx_r <= '0;
      end
      S_SCAN: begin
        if (idx_r == '0) begin
          x0_r  <= rdata_r.x;
          y0_r  <= rdata_r.y;
          idx_r <= idx_r + IDX_W'(1);
        end else if (rdata_r.x > q_r) begin
          x1_r <= rdata_r.x;
          y1_r <= rdata_r.y;
        end else if (idx_r == last_idx) begin
          // past the last segment
          res_r <= rdata_r.y;
          seg_r <= 1'b0;
          sat_r <= 1'b0;
        end else begin
          x0_r  <= rdata_r.x;
          y0_r  <= rdata_r.y;
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      S_PREP: begin
        // zero-width segment gives y0 straight away
        res_r  <= y0_r;
        seg_r  <= 1'b1;
        sat_r  <= 1'b0;
        nq_r   <= {dq_mag, {FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        dmag_r <= den_mag;
        neg_r  <= dq[DATA_W] ^ den[DATA_W];
        lo_r   <= dy;
        step_r <= '0;
      end
      S_DIV: begin
        rem_r  <= div_ge ? div_diff[DATA_W-1:0] : div_part[DATA_W-1:0];
        nq_r   <= {nq_r[NUM_W-2:0], div_ge};
        step_r <= step_r + STEP_W'(1);
      end
      S_FRAC: begin
        if (!neg_r && pos_ovf) begin
          frac_r <= DATA_MAX;
          sat_r  <= 1'b1;
        end else if (neg_r && neg_ovf) begin
          frac_r <= DATA_MIN;
          sat_r  <= 1'b1;
        end else if (neg_r) begin
          frac_r <= -nq_r[DATA_W-1:0];
        end else begin
          frac_r <= nq_r[DATA_W-1:0];
        end
        hi_r   <= '0;
        step_r <= '0;
      end
      S_MUL: begin
        hi_r   <= mul_sum >>> 1;
        lo_r   <= {mul_sum[0], lo_r[LO_W-1:1]};
        step_r <= step_r + STEP_W'(1);
      end
      S_SUM: begin
        if (sum_ovf) begin
          res_r <= sum[SUM_W-1] ? DATA_MIN : DATA_MAX;
          sat_r <= 1'b1;
        end else begin
          res_r <= sum[DATA_W-1:0];
        end
      end
      S_DONE: begin
      end
    endcase
  end

  // output stage: a parked result does not hold up the next input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= res_r;
      out_seg_r   <= seg_r;
      out_sat_r   <= sat_r;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.value      = out_value_r;
  assign out_bus.in_segment = out_seg_r;
  assign out_bus.saturated  = out_sat_r;

endmodule

`default_nettype wire

FILE: rtl/pwl_checker.sv
`default_nettype none

module pwl_checker import pwl_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_mode,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] out_value,
  input wire logic              out_in_segment,
  input wire logic              out_saturated
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat out of reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
      && $stable(out_in_segment) && $stable(out_saturated))
    else $error("stalled result beat changed");

  // past the last segment nothing is clipped
  a_tail_unsat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_segment |-> !out_saturated)
    else $error("saturated flag on a last-point result");

  // a load beat never makes a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_LOAD) && !out_valid |=> !out_valid)
    else $error("result after load beat");

  // a query needs the table scan before any result
  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_QUERY) && !out_valid
      |=> !out_valid ##1 !out_valid)
    else $error("query result too early");

endmodule

bind piecewise_linear_lookup_core pwl_checker u_pwl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .in_mode        (in_bus.mode),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_value      (out_bus.value),
  .out_in_segment (out_bus.in_segment),
  .out_saturated  (out_bus.saturated)
);

`default_nettype wire
